>>> rtl/core/tlbm_pkg.sv
// Shared types, field widths and codes for the paging MMU block.
// Used by tlbm_ctrl, tlbm_dp and the top level under rtl/core; depends on nothing.
package tlbm_pkg;

  // default sizes, handed down by the top level parameters
  localparam int PROCESSES_D   = 4;
  localparam int PAGES_D       = 64;
  localparam int FRAMES_D      = 64;
  localparam int TLB_ENTRIES_D = 8;

  // fixed field widths
  localparam int SLOT_W   = 2;
  localparam int PAGE_W   = 6;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int FRAME_W  = 6;
  localparam int FCNT_W   = 7;
  localparam int TSIZE_W  = 4;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_TLB_HIT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PT_HIT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TERM    = 3'd4;

  // configuration register indexes
  localparam logic CFG_FRAME_COUNT = 1'b0;
  localparam logic CFG_TLB_SIZE    = 1'b1;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DECODE, OP_PTRD, OP_FREE, OP_LRU, OP_LRUE,
    OP_VRD, OP_TINS, OP_TAGE, OP_TWR, OP_REL, OP_OUT
  } op_t;

  // outcome of the decode step
  typedef enum logic [1:0] {K_DONE, K_REL, K_PTRD, K_FAULT} kind_t;

  typedef struct packed {
    op_t  op;
    logic cnt_clr;
    logic cnt_inc;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  free_end;
    logic  free_hit;
    logic  lru_end;
    logic  lru_found;
    logic  tlb_none;
    logic  tlb_inv;
    logic  tage_last;
    logic  rel_last;
    logic  out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/tlbm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package needed.
module tlbm_ram #(
  parameter int W = 8,
  parameter int D = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tlbm_ctrl.sv
// Sequencer for the paging MMU: walks decode, scans, TLB insert and release.
// Depends on tlbm_pkg; drives tlbm_dp through command and status structs.
module tlbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tlbm_pkg::dp_stat_t st,
  output tlbm_pkg::dp_cmd_t  cmd
);
  import tlbm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_PTRD, S_FREE, S_LRU, S_LRUE, S_VRD,
    S_TINS, S_TAGE, S_TWR, S_REL, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.cnt_clr = 1'b0;
    cmd.cnt_inc = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.op      = OP_DECODE;
        cmd.cnt_clr = 1'b1;
        unique case (st.kind)
          K_DONE:  state_nxt = S_DONE;
          K_REL:   state_nxt = S_REL;
          K_PTRD:  state_nxt = S_PTRD;
          K_FAULT: state_nxt = S_FREE;
          default: state_nxt = S_DONE;
        endcase
      end
      S_PTRD: begin
        cmd.op    = OP_PTRD;
        state_nxt = S_TINS;
      end
      S_FREE: begin
        cmd.op = OP_FREE;
        priority if (st.free_end) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_LRU;
        end else if (st.free_hit) begin
          state_nxt = S_TINS;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_LRU: begin
        cmd.op      = OP_LRU;
        cmd.cnt_inc = 1'b1;
        if (st.lru_end) state_nxt = S_LRUE;
      end
      S_LRUE: begin
        cmd.op    = OP_LRUE;
        state_nxt = st.lru_found ? S_VRD : S_DONE;
      end
      S_VRD: begin
        cmd.op    = OP_VRD;
        state_nxt = S_TINS;
      end
      S_TINS: begin
        cmd.op      = OP_TINS;
        cmd.cnt_clr = 1'b1;
        state_nxt   = (st.tlb_none || st.tlb_inv) ? S_DONE : S_TAGE;
      end
      S_TAGE: begin
        cmd.op      = OP_TAGE;
        cmd.cnt_inc = 1'b1;
        if (st.tage_last) state_nxt = S_TWR;
      end
      S_TWR: begin
        cmd.op    = OP_TWR;
        state_nxt = S_DONE;
      end
      S_REL: begin
        cmd.op      = OP_REL;
        cmd.cnt_inc = 1'b1;
        if (st.rel_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/tlbm_dp.sv
// Datapath of the paging MMU: page table RAMs, valid and free bits, TLB,
// scan counter, output register. Depends on tlbm_pkg and tlbm_ram.
module tlbm_dp #(
  parameter int PROCESSES   = tlbm_pkg::PROCESSES_D,
  parameter int PAGES       = tlbm_pkg::PAGES_D,
  parameter int FRAMES      = tlbm_pkg::FRAMES_D,
  parameter int TLB_ENTRIES = tlbm_pkg::TLB_ENTRIES_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tlbm_pkg::dp_cmd_t               cmd,
  output tlbm_pkg::dp_stat_t              st,
  input  logic                            in_mode,
  input  logic [tlbm_pkg::SLOT_W-1:0]     in_slot,
  input  logic [tlbm_pkg::PAGE_W-1:0]     in_page,
  input  logic [tlbm_pkg::LIMIT_W-1:0]    in_limit,
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [tlbm_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tlbm_pkg::STATUS_W-1:0]   out_status,
  output logic [tlbm_pkg::FRAME_W-1:0]    out_frame
);
  import tlbm_pkg::*;

  localparam int PT_DEPTH = PROCESSES * PAGES;
  localparam int PT_W     = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
  localparam int TI_W     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int MAXN0    = (PAGES > FRAMES) ? PAGES : FRAMES;
  localparam int MAXN     = (MAXN0 > TLB_ENTRIES) ? MAXN0 : TLB_ENTRIES;
  localparam int CNT_W    = $clog2(MAXN + 1);

  // latched item and configuration
  logic               mode_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [PAGE_W-1:0]  page_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [FCNT_W-1:0]  frame_count_r;
  logic [TSIZE_W-1:0] tlb_size_r;
  logic [STAMP_W-1:0] clk_stamp_r;

  // residency state
  logic [PT_DEPTH-1:0] page_valid_r;
  logic [FRAMES-1:0]   frame_free_r;

  // TLB entries
  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [PT_W-1:0]        tlb_tag_r   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame_r [TLB_ENTRIES];
  logic [STAMP_W-1:0]     tlb_stamp_r [TLB_ENTRIES];

  // scan state
  logic [CNT_W-1:0]   cnt_r;
  logic               rp_v_r;
  logic               lp_v_r;
  logic [CNT_W-1:0]   lp_idx_r;
  logic               lru_found_r;
  logic [STAMP_W-1:0] lru_best_r;
  logic [CNT_W-1:0]   victim_r;
  logic [STAMP_W-1:0] tbest_r;
  logic [TI_W-1:0]    tpick_r;
  logic [FRAME_W-1:0] ins_frame_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [FRAME_W-1:0]  res_frame_r;

  // RAM ports
  logic               fr_we, st_we;
  logic [FRAME_W-1:0] fr_wdata, fr_rdata;
  logic [PT_W-1:0]    fr_raddr, st_raddr;
  logic [STAMP_W-1:0] st_rdata;

  // derived values
  logic [PT_W-1:0]    base, e, scan_e, victim_e;
  logic               slot_ok, page_bad, good;
  int unsigned        n_fr, n_tlb;
  logic               hit;
  logic [TI_W-1:0]    hidx;
  logic               inv_any;
  logic [TI_W-1:0]    inv_idx;
  logic               free_sel;
  logic [STAMP_W-1:0] tsel_stamp, tage, lage;
  logic               take;

  assign base     = PT_W'(slot_r) * PT_W'(PAGES);
  assign e        = base + PT_W'(page_r);
  assign scan_e   = base + PT_W'(cnt_r);
  assign victim_e = base + PT_W'(victim_r);
  assign slot_ok  = 32'(slot_r) < PROCESSES;
  assign page_bad = ({1'b0, page_r} >= limit_r) || (32'(page_r) >= PAGES);
  assign good     = !mode_r && slot_ok && !page_bad;
  assign n_fr     = (32'(frame_count_r) < FRAMES) ? 32'(frame_count_r) : FRAMES;
  assign n_tlb    = (32'(tlb_size_r) < TLB_ENTRIES) ? 32'(tlb_size_r) : TLB_ENTRIES;
  assign take     = (cmd.op == OP_FREE) && st.free_hit && !st.free_end;

  // TLB lookup, first invalid entry, entry selected by the counter
  always_comb begin
    hit        = 1'b0;
    hidx       = '0;
    inv_any    = 1'b0;
    inv_idx    = '0;
    tsel_stamp = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      if (k < n_tlb && tlb_valid_r[k] && tlb_tag_r[k] == e && !hit) begin
        hit  = 1'b1;
        hidx = TI_W'(k);
      end
      if (k < n_tlb && !tlb_valid_r[k] && !inv_any) begin
        inv_any = 1'b1;
        inv_idx = TI_W'(k);
      end
      if (32'(cnt_r) == k) tsel_stamp = tlb_stamp_r[k];
    end
  end

  // free bit under the counter
  always_comb begin
    free_sel = 1'b0;
    for (int k = 0; k < FRAMES; k++) begin
      if (32'(cnt_r) == k) free_sel = frame_free_r[k];
    end
  end

  assign tage = clk_stamp_r - tsel_stamp;
  assign lage = clk_stamp_r - st_rdata;

  // status to the controller
  always_comb begin
    priority if (mode_r) st.kind = slot_ok ? K_REL : K_DONE;
    else if (!slot_ok)   st.kind = K_DONE;
    else if (page_bad)   st.kind = K_REL;
    else if (hit)        st.kind = K_DONE;
    else if (page_valid_r[e]) st.kind = K_PTRD;
    else                 st.kind = K_FAULT;
    st.free_end  = 32'(cnt_r) >= n_fr;
    st.free_hit  = free_sel;
    st.lru_end   = 32'(cnt_r) == PAGES;
    st.lru_found = lru_found_r;
    st.tlb_none  = (n_tlb == 0);
    st.tlb_inv   = inv_any;
    st.tage_last = (32'(cnt_r) + 1) >= n_tlb;
    st.rel_last  = 32'(cnt_r) == (PAGES - 1);
    st.out_free  = !out_valid || out_ready;
  end

  // frame RAM ports
  always_comb begin
    fr_we    = take || (cmd.op == OP_VRD);
    fr_wdata = (cmd.op == OP_VRD) ? fr_rdata : FRAME_W'(cnt_r);
    unique case (cmd.op)
      OP_REL:  fr_raddr = scan_e;
      OP_LRUE: fr_raddr = victim_e;
      default: fr_raddr = e;
    endcase
  end

  // stamp RAM ports
  assign st_we = ((cmd.op == OP_DECODE) && good && hit) || (cmd.op == OP_PTRD) ||
                 take || (cmd.op == OP_VRD);
  assign st_raddr = scan_e;

  tlbm_ram #(.W(FRAME_W), .D(PT_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (e),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  tlbm_ram #(.W(STAMP_W), .D(PT_DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (e),
    .wdata (clk_stamp_r),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FCNT_W'(64);
      tlb_size_r    <= TSIZE_W'(8);
      clk_stamp_r   <= '0;
      page_valid_r  <= '0;
      frame_free_r  <= '1;
      tlb_valid_r   <= '0;
      cnt_r         <= '0;
      rp_v_r        <= 1'b0;
      lp_v_r        <= 1'b0;
      lru_found_r   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[FCNT_W-1:0];
          CFG_TLB_SIZE:    tlb_size_r    <= cfg_wdata[TSIZE_W-1:0];
          default: ;
        endcase
      end

      // scan counter
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;

      // release pipeline: free the frame read in the cycle before
      rp_v_r <= (cmd.op == OP_REL) && page_valid_r[scan_e];
      if (rp_v_r && 32'(fr_rdata) < FRAMES) begin
        for (int k = 0; k < FRAMES; k++) begin
          if (32'(fr_rdata) == k) frame_free_r[k] <= 1'b1;
        end
      end
      if (cmd.op == OP_REL) page_valid_r[scan_e] <= 1'b0;

      // fault fill from a free frame
      if (take) begin
        for (int k = 0; k < FRAMES; k++) begin
          if (32'(cnt_r) == k) frame_free_r[k] <= 1'b0;
        end
        page_valid_r[e] <= 1'b1;
      end

      // LRU scan over the process's pages
      if (cmd.op == OP_FREE && st.free_end) lru_found_r <= 1'b0;
      lp_v_r <= (cmd.op == OP_LRU) && (32'(cnt_r) < PAGES) && page_valid_r[scan_e];
      if (lp_v_r && (!lru_found_r || lage > lru_best_r)) begin
        lru_found_r <= 1'b1;
      end

      // steal the victim's frame
      if (cmd.op == OP_VRD) begin
        page_valid_r[victim_e] <= 1'b0;
        page_valid_r[e]        <= 1'b1;
      end

      // TLB insert
      if (cmd.op == OP_TINS && n_tlb != 0 && inv_any) tlb_valid_r[inv_idx] <= 1'b1;
      if (cmd.op == OP_TWR) tlb_valid_r[tpick_r] <= 1'b1;

      // result register
      if (cmd.op == OP_OUT) begin
        out_valid   <= 1'b1;
        clk_stamp_r <= clk_stamp_r + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mode_r  <= in_mode;
      slot_r  <= in_slot;
      page_r  <= in_page;
      limit_r <= in_limit;
    end

    // decode result and TLB hit refresh
    if (cmd.op == OP_DECODE) begin
      res_frame_r <= '0;
      priority if (mode_r) res_status_r <= ST_TERM;
      else if (!slot_ok || page_bad) res_status_r <= ST_INVALID;
      else if (hit) begin
        res_status_r      <= ST_TLB_HIT;
        res_frame_r       <= tlb_frame_r[hidx];
        tlb_stamp_r[hidx] <= clk_stamp_r;
      end else if (page_valid_r[e]) res_status_r <= ST_PT_HIT;
      else res_status_r <= ST_FAULT;
    end

    // frame to insert into the TLB
    if (cmd.op == OP_PTRD) begin
      res_frame_r <= fr_rdata;
      ins_frame_r <= fr_rdata;
    end
    if (take) ins_frame_r <= FRAME_W'(cnt_r);
    if (cmd.op == OP_VRD) ins_frame_r <= fr_rdata;

    // oldest resident page
    lp_idx_r <= cnt_r;
    if (lp_v_r && (!lru_found_r || lage > lru_best_r)) begin
      lru_best_r <= lage;
      victim_r   <= lp_idx_r;
    end

    // oldest TLB entry
    if (cmd.op == OP_TAGE && (cnt_r == '0 || tage > tbest_r)) begin
      tbest_r <= tage;
      tpick_r <= cnt_r[TI_W-1:0];
    end

    // TLB entry write
    if (cmd.op == OP_TINS && n_tlb != 0 && inv_any) begin
      tlb_tag_r[inv_idx]   <= e;
      tlb_frame_r[inv_idx] <= ins_frame_r;
      tlb_stamp_r[inv_idx] <= clk_stamp_r;
    end
    if (cmd.op == OP_TWR) begin
      tlb_tag_r[tpick_r]   <= e;
      tlb_frame_r[tpick_r] <= ins_frame_r;
      tlb_stamp_r[tpick_r] <= clk_stamp_r;
    end

    if (cmd.op == OP_OUT) begin
      out_status <= res_status_r;
      out_frame  <= res_frame_r;
    end
  end

endmodule

>>> rtl/core/tlb_page_table_lru_mmu.sv
// Top level of the demand-paging MMU with TLB and per-process LRU.
// Depends on tlbm_pkg, tlbm_ctrl, tlbm_dp and tlbm_ram.
//
// One item in, one result out. An item passes through the accept, decode
// and result stages (the IDLE, DEC and DONE states); a TLB hit takes no
// other state. The block does not take a new item until the last one has
// left its result stage. A page-table hit adds a frame RAM read and a TLB
// insert, and an age scan of min(tlb_size,TLB_ENTRIES) entries when the TLB
// is full. A fault scans frames one per cycle, up to min(frame_count,FRAMES)
// of them. With no frame free, it then scans the process's PAGES page stamps
// one per cycle, drains the scan, and picks and steals the victim's frame
// before the TLB insert. A release or an invalid page walks the PAGES entries
// of the process, one per cycle. The sequencer handles one item at a time.
// The output register lets the next item be accepted while a result waits.
// A stalled receiver holds the following item in its result stage.
module tlb_page_table_lru_mmu #(
  parameter int PROCESSES   = tlbm_pkg::PROCESSES_D,
  parameter int PAGES       = tlbm_pkg::PAGES_D,
  parameter int FRAMES      = tlbm_pkg::FRAMES_D,
  parameter int TLB_ENTRIES = tlbm_pkg::TLB_ENTRIES_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // process_slot, page, page_limit
  input  logic                           in_tuser,   // mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // frame
  output logic [tlbm_pkg::STATUS_W-1:0]  out_tuser,  // status
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [tlbm_pkg::CFG_W-1:0]     cfg_wdata
);
  import tlbm_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           st;
  logic [FRAME_W-1:0] frame;

  assign out_tdata = {2'b00, frame};

  tlbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tlbm_dp #(
    .PROCESSES   (PROCESSES),
    .PAGES       (PAGES),
    .FRAMES      (FRAMES),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_mode    (in_tuser),
    .in_slot    (in_tdata[1:0]),
    .in_page    (in_tdata[7:2]),
    .in_limit   (in_tdata[14:8]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_frame  (frame)
  );

endmodule

>>> verif/tlb_page_table_lru_mmu_tb.sv
// Testbench for tlb_page_table_lru_mmu: drives page references and process-end
// items, predicts each result with an internal paging/TLB model, checks in order.
// Depends on tlbm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tlb_page_table_lru_mmu_tb;
  import tlbm_pkg::*;

  localparam int NPROC = 4;
  localparam int NPAGE = 64;
  localparam int NFRM = 64;
  localparam int NTLB = 8;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic                mode;
    logic [SLOT_W-1:0]   slot;
    logic [PAGE_W-1:0]   page;
    logic [LIMIT_W-1:0]  limit;
  } ref_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
  } xlat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  tlb_page_table_lru_mmu dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  logic [31:0] m_clock;
  logic        m_pvalid [NPROC*NPAGE];
  logic [5:0]  m_pframe [NPROC*NPAGE];
  logic [31:0] m_pstamp [NPROC*NPAGE];
  logic        m_ffree [NFRM];
  logic        m_tvalid [NTLB];
  logic [7:0]  m_ttag [NTLB];
  logic [5:0]  m_tframe [NTLB];
  logic [31:0] m_tstamp [NTLB];
  int          m_fcount, m_tsize;

  ref_item_t pending_refs[$];
  xlat_t     expected_xlats[$];
  int errors = 0;
  int cycles = 0;
  bit send_idle_ok = 1'b1, recv_idle_ok = 1'b1;
  bit recv_hold = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  function automatic void mmu_reset();
    m_clock = 0;
    foreach (m_pvalid[i]) begin
      m_pvalid[i] = 0; m_pframe[i] = 0; m_pstamp[i] = '1;
    end
    foreach (m_ffree[i]) m_ffree[i] = 1;
    foreach (m_tvalid[i]) begin
      m_tvalid[i] = 0; m_ttag[i] = 0; m_tframe[i] = 0; m_tstamp[i] = 0;
    end
    m_fcount = 64;
    m_tsize = 8;
  endfunction

  function automatic void free_process(input int slot);
    for (int j = 0; j < NPAGE; j++)
      if (m_pvalid[slot*NPAGE+j]) begin
        m_ffree[m_pframe[slot*NPAGE+j]] = 1;
        m_pvalid[slot*NPAGE+j] = 0;
      end
  endfunction

  function automatic void tlb_fill(input int tag, input int fr);
    int n, pick;
    logic [31:0] best, age;
    bit found;
    n = (m_tsize < NTLB) ? m_tsize : NTLB;
    pick = 0; best = 0; found = 0;
    if (n == 0) return;
    for (int i = 0; i < n; i++)
      if (!found && !m_tvalid[i]) begin
        pick = i; found = 1;
      end
    if (!found)
      for (int i = 0; i < n; i++) begin
        age = m_clock - m_tstamp[i];
        if (!found || age > best) begin
          best = age; pick = i; found = 1;
        end
      end
    m_tvalid[pick] = 1; m_ttag[pick] = 8'(tag); m_tframe[pick] = 6'(fr);
    m_tstamp[pick] = m_clock;
  endfunction

  function automatic void fault_fill(input int slot, input int pg);
    int base, e, n, victim;
    logic [31:0] best, age;
    bit found;
    base = slot*NPAGE; e = base + pg; n = (m_fcount < NFRM) ? m_fcount : NFRM;
    victim = 0; best = 0; found = 0;
    for (int i = 0; i < n; i++)
      if (m_ffree[i]) begin
        m_ffree[i] = 0; m_pframe[e] = 6'(i); m_pvalid[e] = 1; m_pstamp[e] = m_clock;
        tlb_fill(e, i);
        return;
      end
    for (int i = 0; i < NPAGE; i++)
      if (m_pvalid[base+i]) begin
        age = m_clock - m_pstamp[base+i];
        if (!found || age > best) begin
          best = age; victim = i; found = 1;
        end
      end
    if (!found) return;
    m_pframe[e] = m_pframe[base+victim];
    m_pvalid[base+victim] = 0;
    m_pvalid[e] = 1; m_pstamp[e] = m_clock;
    tlb_fill(e, m_pframe[e]);
  endfunction

  function automatic xlat_t translate(input ref_item_t it);
    xlat_t r;
    int e, n;
    bit hit;
    r.frame = 0; hit = 0;
    if (it.mode) begin
      r.status = ST_TERM;
      free_process(it.slot);
    end else if (it.page >= it.limit) begin
      r.status = ST_INVALID;
      free_process(it.slot);
    end else begin
      e = it.slot*NPAGE + it.page;
      n = (m_tsize < NTLB) ? m_tsize : NTLB;
      for (int i = 0; i < n; i++)
        if (!hit && m_tvalid[i] && m_ttag[i] == e) begin
          m_tstamp[i] = m_clock; m_pstamp[e] = m_clock;
          r.frame = m_tframe[i]; hit = 1;
        end
      if (hit) r.status = ST_TLB_HIT;
      else if (m_pvalid[e]) begin
        r.status = ST_PT_HIT;
        r.frame = m_pframe[e];
        tlb_fill(e, r.frame);
        m_pstamp[e] = m_clock;
      end else begin
        r.status = ST_FAULT;
        fault_fill(it.slot, it.page);
      end
    end
    m_clock++;
    return r;
  endfunction

  // driver: present queued items, idle at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_xlats.push_back(translate(pending_refs.pop_front()));
      end
      if ((!in_tvalid || in_tready) && pending_refs.size() > 0 &&
          !(in_tvalid && in_tready && pending_refs.size() == 0) &&
          (!send_idle_ok || $urandom_range(99) >= 25)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, pending_refs[0].limit, pending_refs[0].page, pending_refs[0].slot};
        in_tuser <= pending_refs[0].mode;
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check results in order
  always @(posedge clk) begin
    xlat_t w;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_xlats.size() == 0) report("unexpected result", out_tuser, -1);
        else begin
          w = expected_xlats.pop_front();
          if (out_tuser !== w.status) report("status", out_tuser, w.status);
          if (out_tdata !== {2'b0, w.frame}) report("frame", out_tdata, w.frame);
        end
      end
      out_tready <= !recv_hold && (!recv_idle_ok || $urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_ref(input bit mode, input int slot, input int page, input int limit);
    ref_item_t it;
    it.mode = mode;
    it.slot = SLOT_W'(slot);
    it.page = PAGE_W'(page);
    it.limit = LIMIT_W'(limit);
    pending_refs.push_back(it);
  endtask

  task automatic drain();
    while (pending_refs.size() > 0 || in_tvalid || expected_xlats.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= CFG_W'(value);
    if (idx == CFG_FRAME_COUNT) m_fcount = value; else m_tsize = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: mostly in-range references over a working set, some releases
  task automatic random_refs(input int count, input int span);
    int s, r;
    for (int k = 0; k < count; k++) begin
      s = $urandom_range(3); r = $urandom_range(99);
      if (r < 4) add_ref(1, s, $urandom_range(63), $urandom_range(127));
      else if (r < 8) add_ref(0, s, $urandom_range(63), $urandom_range(64));
      else if (r < 10) add_ref(0, s, $urandom_range(63), $urandom_range(127));
      else add_ref(0, s, $urandom_range(span-1), 64);
    end
  endtask

  initial begin
    mmu_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, hits, invalid pages, releases
    add_ref(0, 0, 0, 64);
    add_ref(0, 0, 0, 64);
    add_ref(0, 3, 63, 64);
    add_ref(0, 3, 63, 127);
    add_ref(0, 1, 5, 5);
    add_ref(0, 1, 0, 0);
    add_ref(0, 2, 10, 20);
    add_ref(1, 2, 63, 127);
    add_ref(0, 2, 10, 20);
    for (int p = 0; p < 9; p++) add_ref(0, 0, p, 64);
    add_ref(0, 0, 0, 64);
    add_ref(0, 3, 63, 64);
    add_ref(1, 0, 42, 85);
    drain();

    // tiny memory: force LRU eviction, frame exhaustion
    write_reg(CFG_FRAME_COUNT, 2);
    write_reg(CFG_TLB_SIZE, 1);
    add_ref(0, 1, 1, 64); add_ref(0, 1, 2, 64); add_ref(0, 1, 3, 64);
    add_ref(0, 2, 4, 64); add_ref(0, 1, 1, 64);
    random_refs(80, 6);
    drain();

    write_reg(CFG_FRAME_COUNT, 0);
    write_reg(CFG_TLB_SIZE, 0);
    random_refs(30, 4);
    drain();

    write_reg(CFG_FRAME_COUNT, 127);
    write_reg(CFG_TLB_SIZE, 15);
    random_refs(60, 12);
    // receiver holds off while the sender keeps offering
    recv_hold = 1'b1;
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
    drain();

    write_reg(CFG_FRAME_COUNT, 64);
    write_reg(CFG_TLB_SIZE, 8);
    send_idle_ok = 0; recv_idle_ok = 0;
    random_refs(150, 16);
    drain();
    send_idle_ok = 1; recv_idle_ok = 1;

    write_reg(CFG_FRAME_COUNT, 9);
    write_reg(CFG_TLB_SIZE, 4);
    random_refs(200, 20);
    drain();

    write_reg(CFG_FRAME_COUNT, 1);
    write_reg(CFG_TLB_SIZE, 8);
    random_refs(100, 8);
    drain();

    write_reg(CFG_FRAME_COUNT, 40);
    write_reg(CFG_TLB_SIZE, 3);
    random_refs(140, 64);
    drain();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
